@@ design/csvft_pkg.sv @@
// shared types and constants for the csv field tokenizer
package csvft_pkg;

  localparam int ROW_BITS_DEF = 16;
  localparam int COL_BITS_DEF = 10;

  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_LF    = 8'd10;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_CELL    = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    Q_OUT  = 2'd0,
    Q_IN   = 2'd1,
    Q_PEND = 2'd2
  } qmode_t;

endpackage

@@ design/csv_field_tokenizer_unit.sv @@
// csv field tokenizer: tags content bytes with row and column, marks cell ends
//
// Input stream (s_*): one request per text byte, s_tdata carries the byte,
// s_tuser is the flush flag that closes an unterminated last line.
// Output stream (m_*): zero or one request per input. m_tuser gives the kind
// (content byte, cell complete, open cell discarded); m_tdata carries the
// byte, row index and column index of the cell.
// A result appears on m_* in the cycle after its input is accepted.
// Throughput is one input per cycle unless the receiver stalls; the next
// tokenizer state is combinational and one output register holds the result.
// When the receiver stalls, the output register holds its request and
// s_tready drops until it is taken; s_tready is high whenever the output
// register is empty or being drained in the same cycle.
// Reset clears the quote state, row and column counters and the output valid.
// Row and column counters saturate at their maximum.
module csv_field_tokenizer_unit
  import csvft_pkg::*;
#(
  parameter int ROW_BITS = ROW_BITS_DEF,
  parameter int COL_BITS = COL_BITS_DEF,
  localparam int OUT_W = ((8 + ROW_BITS + COL_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // data_byte
  input  logic             s_tuser,   // flush
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // out_byte, cell_row, cell_col, zero pad
  output logic [1:0]       m_tuser    // kind
);

  localparam int PAD_W = OUT_W - (8 + ROW_BITS + COL_BITS);

  qmode_t              quote_mode, quote_mode_next;
  logic [ROW_BITS-1:0] row_index, row_index_next;
  logic [COL_BITS-1:0] col_index, col_index_next;
  logic                line_open, line_open_next;

  logic                emit;
  kind_t               emit_kind;
  logic [7:0]          emit_byte;
  logic                s_accept;

  logic [7:0]          out_byte;
  logic [ROW_BITS-1:0] cell_row;
  logic [COL_BITS-1:0] cell_col;
  kind_t               out_kind;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  always_comb begin
    qmode_t mode;
    logic   end_line;
    mode            = quote_mode;
    end_line        = 1'b0;
    quote_mode_next = quote_mode;
    row_index_next  = row_index;
    col_index_next  = col_index;
    line_open_next  = line_open;
    emit            = 1'b0;
    emit_kind       = KIND_BYTE;
    emit_byte       = 8'd0;

    if (s_tuser) begin
      if (line_open) begin
        end_line = 1'b1;
      end
    end else begin
      line_open_next = 1'b1;
      if (mode == Q_PEND) begin
        if (s_tdata == CH_QUOTE) begin
          quote_mode_next = Q_IN;
          emit            = 1'b1;
          emit_byte       = CH_QUOTE;
        end else begin
          mode = Q_OUT;
        end
      end
      if (mode == Q_IN) begin
        if (s_tdata == CH_QUOTE) begin
          quote_mode_next = Q_PEND;
        end else if (s_tdata == CH_LF) begin
          end_line = 1'b1;
        end else begin
          emit      = 1'b1;
          emit_byte = s_tdata;
        end
      end else if (mode != Q_PEND) begin
        quote_mode_next = Q_OUT;
        if (s_tdata == CH_QUOTE) begin
          quote_mode_next = Q_IN;
        end else if (s_tdata == CH_COMMA) begin
          emit      = 1'b1;
          emit_kind = KIND_CELL;
          if (col_index != {COL_BITS{1'b1}}) begin
            col_index_next = col_index + 1'b1;
          end
        end else if (s_tdata == CH_LF) begin
          end_line = 1'b1;
        end else begin
          emit      = 1'b1;
          emit_byte = s_tdata;
        end
      end
    end

    if (end_line) begin
      emit      = 1'b1;
      emit_kind = (quote_mode == Q_IN) ? KIND_DISCARD : KIND_CELL;
      if (row_index != {ROW_BITS{1'b1}}) begin
        row_index_next = row_index + 1'b1;
      end
      col_index_next  = '0;
      line_open_next  = 1'b0;
      quote_mode_next = Q_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode <= Q_OUT;
      row_index  <= '0;
      col_index  <= '0;
      line_open  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_accept) begin
        quote_mode <= quote_mode_next;
        row_index  <= row_index_next;
        col_index  <= col_index_next;
        line_open  <= line_open_next;
        m_tvalid   <= emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && emit) begin
      out_kind <= emit_kind;
      out_byte <= emit_byte;
      cell_row <= row_index;
      cell_col <= col_index;
    end
  end

  generate
    if (PAD_W > 0) begin : g_pad
      assign m_tdata = {{PAD_W{1'b0}}, cell_col, cell_row, out_byte};
    end else begin : g_nopad
      assign m_tdata = {cell_col, cell_row, out_byte};
    end
  endgenerate

  assign m_tuser = out_kind;

  a_pend_open: assert property (@(posedge clk) disable iff (rst)
    (quote_mode == Q_PEND) |-> line_open)
    else $error("pending quote without an open line");

  a_col_open: assert property (@(posedge clk) disable iff (rst)
    (col_index != '0) |-> line_open)
    else $error("column advanced without an open line");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (s_accept && emit) |=> m_tvalid)
    else $error("result lost after accepted input");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_BYTE || m_tuser == KIND_CELL ||
                  m_tuser == KIND_DISCARD))
    else $error("illegal result kind");

endmodule
